/* rtl/core/wall_grid_rectangle_merge_top_defines.svh */
// Assertion helpers used by the rectangle merge top module.
`ifndef WALL_GRID_RECTANGLE_MERGE_TOP_DEFINES_SVH
`define WALL_GRID_RECTANGLE_MERGE_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WGRM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WGRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/wgrm_pkg.sv */
package wgrm_pkg;

   // Default grid geometry
   localparam int MAX_COLS_DEF  = 64;
   localparam int MAX_ROWS_DEF  = 64;
   localparam int CELL_BITS_DEF = 4;

   // Fixed field widths
   localparam int GRID_REG_W = 7;
   localparam int MASK_W     = 16;
   localparam int CELL_IN_W  = 4;
   localparam int CORNER_W   = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [GRID_REG_W-1:0] GRID_COLS_RST = 7'd64;
   localparam logic [GRID_REG_W-1:0] GRID_ROWS_RST = 7'd64;
   localparam logic [MASK_W-1:0]     WALL_MASK_RST = 16'h0000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_MASK = 2'd2;

   // Opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LAUNCH,
      ST_SEARCH,
      ST_GROW_R,
      ST_GROW_D,
      ST_MARK
   } wgrm_state_type;

   typedef struct packed {
      logic cell_we;
      logic cov_we;
      logic cov_set;
   } wgrm_mem_ctl_type;

   typedef struct packed {
      logic wall;
      logic covered;
   } wgrm_mem_stat_type;

   // Index width for a store of the given depth, never below one bit
   function automatic int wgrm_addr_w(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

/* rtl/core/wgrm_grid_mem.sv */
module wgrm_grid_mem #(
   parameter int MAX_COLS  = wgrm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS  = wgrm_pkg::MAX_ROWS_DEF,
   parameter int CELL_BITS = wgrm_pkg::CELL_BITS_DEF
) (
   input  logic                                                clock,
   input  wgrm_pkg::wgrm_mem_ctl_type                          mem_ctl,
   input  logic [wgrm_pkg::wgrm_addr_w(MAX_COLS*MAX_ROWS)-1:0] rd_addr,
   input  logic [wgrm_pkg::wgrm_addr_w(MAX_COLS*MAX_ROWS)-1:0] cell_waddr,
   input  logic [CELL_BITS-1:0]                                cell_wdata,
   input  logic [wgrm_pkg::wgrm_addr_w(MAX_COLS*MAX_ROWS)-1:0] cov_waddr,
   input  logic [wgrm_pkg::MASK_W-1:0]                         wall_mask,
   output wgrm_pkg::wgrm_mem_stat_type                         mem_stat
);
   import wgrm_pkg::*;

   localparam int DEPTH = MAX_COLS * MAX_ROWS;

   logic [CELL_BITS-1:0] cell_mem [DEPTH];
   logic                 cov_mem  [DEPTH];
   logic [CELL_BITS-1:0] cell_rd_ff;
   logic                 cov_rd_ff;
   logic [5:0]           code;

   always_ff @(posedge clock) begin
      if (mem_ctl.cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_rd_ff <= cell_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.cov_we) begin
         cov_mem[cov_waddr] <= mem_ctl.cov_set;
      end
      cov_rd_ff <= cov_mem[rd_addr];
   end

   // Codes of sixteen and above never count as wall
   assign code             = 6'(cell_rd_ff);
   assign mem_stat.wall    = (code[5:4] == 2'b00) && wall_mask[code[3:0]];
   assign mem_stat.covered = cov_rd_ff;

endmodule

/* rtl/core/wall_grid_rectangle_merge_top.sv */
// Greedy wall-rectangle cover of a tile grid held in on-chip memory.
// Input channel: a word is taken at a rising edge with start high and busy low.
//   Opcode load writes req_cell_value at the next raster position; it
//   produces no result and leaves busy low.
//   Opcode fetch returns the next rectangle, or done once the cover is used up.
// Result channel: rsp_valid is high for one cycle with the corners and done
//   flag; the receiver must take it then, it cannot hold results off. The
//   strobe comes in the same cycle that busy falls, and the next word may be
//   started in that same cycle.
// Fetch sequence, from accept to strobe: a launch step, then the search steps
//   past cells, grows right cell by cell, tests cells while growing down, and
//   marks each cell covered. A fetch that opens a new scan on a non-empty grid
//   first clears the coverage map over its cols*rows entries, one entry a cycle.
// The rate is set by the single read port shared by the cell store and the
//   coverage map: every cell test is one read, every mark one write.
// Configuration: csr_valid/csr_ready write port, always ready; to be written while idle, which
//   the block does not enforce. Writing a known register, or loading a cell, cancels the scan.
// Reset: synchronous, active high; grid 64 x 64, empty wall mask, load and
//   scan positions at zero. Cell store contents are undefined until loaded.
module wall_grid_rectangle_merge_top #(
   parameter int MAX_COLS  = wgrm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS  = wgrm_pkg::MAX_ROWS_DEF,
   parameter int CELL_BITS = wgrm_pkg::CELL_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_opcode,
   input  logic [wgrm_pkg::CELL_IN_W-1:0]  req_cell_value,
   output logic                            rsp_valid,
   output logic [wgrm_pkg::CORNER_W-1:0]   rsp_rect_x0,
   output logic [wgrm_pkg::CORNER_W-1:0]   rsp_rect_y0,
   output logic [wgrm_pkg::CORNER_W-1:0]   rsp_rect_x1,
   output logic [wgrm_pkg::CORNER_W-1:0]   rsp_rect_y1,
   output logic                            rsp_done_res,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wgrm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wgrm_pkg::CSR_DATA_W-1:0] csr_data
);
   import wgrm_pkg::*;

   `include "wall_grid_rectangle_merge_top_defines.svh"

   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = wgrm_addr_w(DEPTH);
   localparam int XW     = wgrm_addr_w(MAX_COLS);
   localparam int YW     = wgrm_addr_w(MAX_ROWS);
   localparam int XCW    = $clog2(MAX_COLS + 1);
   localparam int YCW    = $clog2(MAX_ROWS + 1);
   localparam int XCW1   = XCW + 1;
   localparam int YCW1   = YCW + 1;
   localparam int AREA_W = $clog2(DEPTH + 1);
   localparam int GCW    = (XCW > GRID_REG_W) ? XCW : GRID_REG_W;
   localparam int GRW    = (YCW > GRID_REG_W) ? YCW : GRID_REG_W;

   // Control state
   wgrm_state_type          state_ff, state_in;
   logic [GRID_REG_W-1:0]   grid_cols_ff, grid_cols_in;
   logic [GRID_REG_W-1:0]   grid_rows_ff, grid_rows_in;
   logic [MASK_W-1:0]       wall_mask_ff, wall_mask_in;
   logic [ADDR_W-1:0]       load_ptr_ff, load_ptr_in;
   logic                    scan_act_ff, scan_act_in;
   logic [XW-1:0]           scan_col_ff, scan_col_in;
   logic [YCW-1:0]          scan_row_ff, scan_row_in;
   logic [ADDR_W-1:0]       scan_addr_ff, scan_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Walk cursor and rectangle under construction
   logic [XCW-1:0]          cur_x_ff, cur_x_in;
   logic [YCW-1:0]          cur_y_ff, cur_y_in;
   logic [ADDR_W-1:0]       cur_addr_ff, cur_addr_in;
   logic [ADDR_W-1:0]       row_addr_ff, row_addr_in;
   logic [XW-1:0]           x0_ff, x0_in;
   logic [YW-1:0]           y0_ff, y0_in;
   logic [ADDR_W-1:0]       a0_ff, a0_in;
   logic [XW-1:0]           x1_ff, x1_in;
   logic [YW-1:0]           y1_ff, y1_in;

   // Result word
   logic [CORNER_W-1:0]     rsp_x0_ff, rsp_x0_in;
   logic [CORNER_W-1:0]     rsp_y0_ff, rsp_y0_in;
   logic [CORNER_W-1:0]     rsp_x1_ff, rsp_x1_in;
   logic [CORNER_W-1:0]     rsp_y1_ff, rsp_y1_in;
   logic                    rsp_done_ff, rsp_done_in;

   // Geometry and decode
   logic [GCW-1:0]          gc_ext;
   logic [GRW-1:0]          gr_ext;
   logic [XCW-1:0]          cols;
   logic [YCW-1:0]          rows;
   logic [XCW+YCW-1:0]      area_full;
   logic [AREA_W-1:0]       area;
   logic [AREA_W-1:0]       ptr_inc;
   logic [AREA_W-1:0]       load_lim;
   logic [XCW1-1:0]         cur_x_inc;
   logic [YCW1-1:0]         cur_y_inc;
   logic [XCW1-1:0]         x0_inc;
   logic [ADDR_W-1:0]       row_next;
   logic                    csr_we;
   logic                    accept;
   logic                    in_grid;
   logic                    hit;
   logic                    search_end;
   logic                    search_hit;
   logic                    x_last;
   logic                    y_last;
   logic                    clr_last;

   wgrm_mem_ctl_type        mem_ctl;
   wgrm_mem_stat_type       mem_stat;
   logic [CELL_BITS-1:0]    cell_wdata;

   // Effective grid size: register values above the store size act as the maximum
   assign gc_ext    = GCW'(grid_cols_ff);
   assign gr_ext    = GRW'(grid_rows_ff);
   assign cols      = (gc_ext > GCW'(MAX_COLS)) ? XCW'(MAX_COLS) : XCW'(gc_ext);
   assign rows      = (gr_ext > GRW'(MAX_ROWS)) ? YCW'(MAX_ROWS) : YCW'(gr_ext);
   assign area_full = cols * rows;
   assign area      = AREA_W'(area_full);

   // Load pointer wraps at the area, or at the full store for an empty grid
   assign ptr_inc  = AREA_W'(load_ptr_ff) + AREA_W'(1);
   assign load_lim = (area == '0) ? AREA_W'(DEPTH) : area;

   assign cur_x_inc = XCW1'(cur_x_ff) + XCW1'(1);
   assign cur_y_inc = YCW1'(cur_y_ff) + YCW1'(1);
   assign x0_inc    = XCW1'(x0_ff) + XCW1'(1);
   assign row_next  = ADDR_W'(row_addr_ff + ADDR_W'(cols));

   assign csr_we  = csr_valid & csr_ready;
   assign accept  = start & ~busy;

   // The memory output always belongs to the cell under the cursor
   assign in_grid    = (cur_x_ff < cols) && (cur_y_ff < rows);
   assign hit        = in_grid && mem_stat.wall;
   assign search_end = (cur_y_ff >= rows);
   assign search_hit = hit && !mem_stat.covered;
   assign x_last     = (cur_x_ff == XCW'(x1_ff));
   assign y_last     = (cur_y_ff == YCW'(y1_ff));
   assign clr_last   = ((AREA_W'(cur_addr_ff) + AREA_W'(1)) == area);

   assign cell_wdata = CELL_BITS'(req_cell_value);

   wgrm_grid_mem #(
      .MAX_COLS  (MAX_COLS),
      .MAX_ROWS  (MAX_ROWS),
      .CELL_BITS (CELL_BITS)
   ) u_grid_mem (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .rd_addr    (cur_addr_in),
      .cell_waddr (load_ptr_ff),
      .cell_wdata (cell_wdata),
      .cov_waddr  (cur_addr_ff),
      .wall_mask  (wall_mask_ff),
      .mem_stat   (mem_stat)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_FETCH)) begin
               if (scan_act_ff || (area == '0)) begin
                  state_in = ST_LAUNCH;
               end else begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (search_end) begin
               state_in = ST_IDLE;
            end else if (search_hit) begin
               state_in = ST_GROW_R;
            end
         end
         ST_GROW_R: begin
            if (!hit) begin
               state_in = ST_GROW_D;
            end
         end
         ST_GROW_D: begin
            if (!hit) begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (x_last && y_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control
   always_comb begin
      grid_cols_in = grid_cols_ff;
      grid_rows_in = grid_rows_ff;
      wall_mask_in = wall_mask_ff;
      load_ptr_in  = load_ptr_ff;
      scan_act_in  = scan_act_ff;
      scan_col_in  = scan_col_ff;
      scan_row_in  = scan_row_ff;
      scan_addr_in = scan_addr_ff;
      rsp_valid_in = 1'b0;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_addr_in  = cur_addr_ff;
      row_addr_in  = row_addr_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      a0_in        = a0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      rsp_x0_in    = rsp_x0_ff;
      rsp_y0_in    = rsp_y0_ff;
      rsp_x1_in    = rsp_x1_ff;
      rsp_y1_in    = rsp_y1_ff;
      rsp_done_in  = rsp_done_ff;
      mem_ctl      = '0;

      // Register writes are to be made while idle, which the block does not enforce; a known register cancels the scan
      if (csr_we) begin
         case (csr_index)
            CSR_GRID_COLS: begin
               grid_cols_in = csr_data[GRID_REG_W-1:0];
               scan_act_in  = 1'b0;
               scan_col_in  = '0;
               scan_row_in  = '0;
               scan_addr_in = '0;
            end
            CSR_GRID_ROWS: begin
               grid_rows_in = csr_data[GRID_REG_W-1:0];
               scan_act_in  = 1'b0;
               scan_col_in  = '0;
               scan_row_in  = '0;
               scan_addr_in = '0;
            end
            CSR_WALL_MASK: begin
               wall_mask_in = csr_data[MASK_W-1:0];
               scan_act_in  = 1'b0;
               scan_col_in  = '0;
               scan_row_in  = '0;
               scan_addr_in = '0;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_LOAD) begin
                  // Store the cell, advance the raster pointer, drop the scan
                  mem_ctl.cell_we = 1'b1;
                  if (ptr_inc >= load_lim) begin
                     load_ptr_in = '0;
                  end else begin
                     load_ptr_in = ADDR_W'(ptr_inc);
                  end
                  scan_act_in  = 1'b0;
                  scan_col_in  = '0;
                  scan_row_in  = '0;
                  scan_addr_in = '0;
               end else if (!scan_act_ff) begin
                  // Open a new scan at the origin; the clear sweep starts at entry zero
                  scan_act_in  = 1'b1;
                  scan_col_in  = '0;
                  scan_row_in  = '0;
                  scan_addr_in = '0;
                  cur_addr_in  = '0;
               end
            end
         end
         ST_CLEAR: begin
            mem_ctl.cov_we  = 1'b1;
            mem_ctl.cov_set = 1'b0;
            cur_addr_in     = ADDR_W'(cur_addr_ff + ADDR_W'(1));
         end
         ST_LAUNCH: begin
            // Point the read port at the saved scan position
            cur_x_in    = XCW'(scan_col_ff);
            cur_y_in    = scan_row_ff;
            cur_addr_in = scan_addr_ff;
         end
         ST_SEARCH: begin
            if (search_end) begin
               // Cover used up: report done and rewind
               scan_act_in  = 1'b0;
               scan_col_in  = '0;
               scan_row_in  = '0;
               scan_addr_in = '0;
               rsp_valid_in = 1'b1;
               rsp_x0_in    = '0;
               rsp_y0_in    = '0;
               rsp_x1_in    = '0;
               rsp_y1_in    = '0;
               rsp_done_in  = 1'b1;
            end else if (search_hit) begin
               x0_in       = XW'(cur_x_ff);
               y0_in       = YW'(cur_y_ff);
               a0_in       = cur_addr_ff;
               x1_in       = XW'(cur_x_ff);
               y1_in       = YW'(cur_y_ff);
               cur_x_in    = XCW'(cur_x_inc);
               cur_addr_in = ADDR_W'(cur_addr_ff + ADDR_W'(1));
            end else begin
               // Step to the next cell in raster order
               if (cur_x_inc >= XCW1'(cols)) begin
                  cur_x_in = '0;
                  cur_y_in = YCW'(cur_y_inc);
               end else begin
                  cur_x_in = XCW'(cur_x_inc);
               end
               cur_addr_in = ADDR_W'(cur_addr_ff + ADDR_W'(1));
            end
         end
         ST_GROW_R: begin
            if (hit) begin
               x1_in       = XW'(cur_x_ff);
               cur_x_in    = XCW'(cur_x_inc);
               cur_addr_in = ADDR_W'(cur_addr_ff + ADDR_W'(1));
            end else begin
               // Span fixed; test the row below from its left end
               cur_x_in    = XCW'(x0_ff);
               cur_y_in    = YCW'(YCW'(y0_ff) + YCW'(1));
               cur_addr_in = ADDR_W'(a0_ff + ADDR_W'(cols));
               row_addr_in = ADDR_W'(a0_ff + ADDR_W'(cols));
            end
         end
         ST_GROW_D: begin
            if (hit) begin
               if (x_last) begin
                  // Whole span is wall: take the row and move one further down
                  y1_in       = YW'(cur_y_ff);
                  cur_x_in    = XCW'(x0_ff);
                  cur_y_in    = YCW'(cur_y_inc);
                  cur_addr_in = row_next;
                  row_addr_in = row_next;
               end else begin
                  cur_x_in    = XCW'(cur_x_inc);
                  cur_addr_in = ADDR_W'(cur_addr_ff + ADDR_W'(1));
               end
            end else begin
               // Rewind the cursor to the top-left corner for marking
               cur_x_in    = XCW'(x0_ff);
               cur_y_in    = YCW'(y0_ff);
               cur_addr_in = a0_ff;
               row_addr_in = a0_ff;
            end
         end
         ST_MARK: begin
            mem_ctl.cov_we  = 1'b1;
            mem_ctl.cov_set = 1'b1;
            if (x_last) begin
               if (y_last) begin
                  // Rectangle covered: resume just after its corner next time
                  if (x0_inc >= XCW1'(cols)) begin
                     scan_col_in = '0;
                     scan_row_in = YCW'(YCW'(y0_ff) + YCW'(1));
                  end else begin
                     scan_col_in = XW'(x0_inc);
                     scan_row_in = YCW'(y0_ff);
                  end
                  scan_addr_in = ADDR_W'(a0_ff + ADDR_W'(1));
                  rsp_valid_in = 1'b1;
                  rsp_x0_in    = CORNER_W'(x0_ff);
                  rsp_y0_in    = CORNER_W'(y0_ff);
                  rsp_x1_in    = CORNER_W'(x1_ff);
                  rsp_y1_in    = CORNER_W'(y1_ff);
                  rsp_done_in  = 1'b0;
               end else begin
                  cur_x_in    = XCW'(x0_ff);
                  cur_y_in    = YCW'(cur_y_inc);
                  cur_addr_in = row_next;
                  row_addr_in = row_next;
               end
            end else begin
               cur_x_in    = XCW'(cur_x_inc);
               cur_addr_in = ADDR_W'(cur_addr_ff + ADDR_W'(1));
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grid_cols_ff <= GRID_COLS_RST;
         grid_rows_ff <= GRID_ROWS_RST;
         wall_mask_ff <= WALL_MASK_RST;
         load_ptr_ff  <= '0;
         scan_act_ff  <= 1'b0;
         scan_col_ff  <= '0;
         scan_row_ff  <= '0;
         scan_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_cols_ff <= grid_cols_in;
         grid_rows_ff <= grid_rows_in;
         wall_mask_ff <= wall_mask_in;
         load_ptr_ff  <= load_ptr_in;
         scan_act_ff  <= scan_act_in;
         scan_col_ff  <= scan_col_in;
         scan_row_ff  <= scan_row_in;
         scan_addr_ff <= scan_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Cursor, rectangle and result word
   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cur_addr_ff <= cur_addr_in;
      row_addr_ff <= row_addr_in;
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      a0_ff       <= a0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      rsp_x0_ff   <= rsp_x0_in;
      rsp_y0_ff   <= rsp_y0_in;
      rsp_x1_ff   <= rsp_x1_in;
      rsp_y1_ff   <= rsp_y1_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rect_x0  = rsp_x0_ff;
   assign rsp_rect_y0  = rsp_y0_ff;
   assign rsp_rect_x1  = rsp_x1_ff;
   assign rsp_rect_y1  = rsp_y1_ff;
   assign rsp_done_res = rsp_done_ff;

   `WGRM_ASSERT_IMPL(a_rsp_in_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE, "result strobe outside idle")
   `WGRM_ASSERT_IMPL(a_rect_ordered, clock, reset, (state_ff == ST_GROW_R) || (state_ff == ST_GROW_D) || (state_ff == ST_MARK), (x1_ff >= x0_ff) && (y1_ff >= y0_ff), "rectangle corners out of order")
   `WGRM_ASSERT_IMPL(a_mark_inside, clock, reset, state_ff == ST_MARK, (cur_x_ff <= XCW'(x1_ff)) && (cur_y_ff <= YCW'(y1_ff)) && (cur_y_ff >= YCW'(y0_ff)), "mark cursor left the rectangle")
   `WGRM_ASSERT_IMPL(a_idle_scan_home, clock, reset, !scan_act_ff, (scan_addr_ff == '0) && (scan_col_ff == '0) && (scan_row_ff == '0), "inactive scan away from origin")
   `WGRM_ASSERT_NEXT(a_fetch_busy, clock, reset, (state_ff == ST_IDLE) && start && (req_opcode == OP_FETCH), busy, "fetch did not raise busy")

endmodule

/* dv/rect_cover_checker.sv */
module rect_cover_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            req_opcode,
   input  logic [wgrm_pkg::CELL_IN_W-1:0]  req_cell_value,
   input  logic                            rsp_valid,
   input  logic [wgrm_pkg::CORNER_W-1:0]   rsp_rect_x0,
   input  logic [wgrm_pkg::CORNER_W-1:0]   rsp_rect_y0,
   input  logic [wgrm_pkg::CORNER_W-1:0]   rsp_rect_x1,
   input  logic [wgrm_pkg::CORNER_W-1:0]   rsp_rect_y1,
   input  logic                            rsp_done_res,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [wgrm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wgrm_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              fail_count,
   output int                              rect_pending
);
   import wgrm_pkg::*;

   localparam int STORE_DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF;

   typedef struct packed {
      logic [CORNER_W-1:0] x0;
      logic [CORNER_W-1:0] y0;
      logic [CORNER_W-1:0] x1;
      logic [CORNER_W-1:0] y1;
      logic                done;
   } rect_word_t;

   bit [CELL_BITS_DEF-1:0] cell_mem [STORE_DEPTH];
   bit                     cov_map  [STORE_DEPTH];
   logic [GRID_REG_W-1:0]  cols_q;
   logic [GRID_REG_W-1:0]  rows_q;
   logic [MASK_W-1:0]      mask_q;
   int                     load_ptr;
   int                     scan_c;
   int                     scan_r;
   bit                     scan_on;
   rect_word_t             pending_rects [$];

   initial fail_count = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (fail_count < 100)
         $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic int eff_cols();
      return (cols_q > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_q);
   endfunction

   function automatic int eff_rows();
      return (rows_q > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_q);
   endfunction

   // Outside the grid is never wall
   function automatic bit wall_at(input int x, input int y, input int cols, input int rows);
      if (x >= cols || y >= rows)
         return 1'b0;
      return mask_q[cell_mem[(y * cols + x) % STORE_DEPTH]];
   endfunction

   task automatic drop_scan();
      scan_on = 1'b0;
      scan_c  = 0;
      scan_r  = 0;
   endtask

   task automatic store_code(input logic [CELL_IN_W-1:0] code);
      int limit;
      limit = eff_cols() * eff_rows();
      if (limit == 0)
         limit = STORE_DEPTH;
      cell_mem[load_ptr % STORE_DEPTH] = code[CELL_BITS_DEF-1:0];
      load_ptr++;
      if (load_ptr >= limit)
         load_ptr = 0;
      drop_scan();
   endtask

   task automatic predict_rect();
      int         cols, rows, x, y, x0, y0, x1, y1, i;
      bit         found, full;
      rect_word_t w;
      cols  = eff_cols();
      rows  = eff_rows();
      found = 1'b0;
      x0    = 0;
      y0    = 0;
      if (!scan_on) begin
         for (i = 0; i < STORE_DEPTH; i++)
            cov_map[i] = 1'b0;
         scan_c  = 0;
         scan_r  = 0;
         scan_on = 1'b1;
      end
      // Find the next uncovered wall cell from the scan position
      y = scan_r;
      while (y < rows && !found) begin
         x = (y == scan_r) ? scan_c : 0;
         while (x < cols && !found) begin
            if (wall_at(x, y, cols, rows) && !cov_map[(y * cols + x) % STORE_DEPTH]) begin
               x0    = x;
               y0    = y;
               found = 1'b1;
            end
            x++;
         end
         y++;
      end
      w = '0;
      if (!found) begin
         drop_scan();
         w.done = 1'b1;
         pending_rects.push_back(w);
         return;
      end
      // Grow right, then down while the whole span stays wall
      x1 = x0;
      while (wall_at(x1 + 1, y0, cols, rows))
         x1++;
      y1   = y0;
      full = 1'b1;
      while (full) begin
         for (x = x0; x <= x1; x++)
            if (!wall_at(x, y1 + 1, cols, rows))
               full = 1'b0;
         if (full)
            y1++;
      end
      for (y = y0; y <= y1; y++)
         for (x = x0; x <= x1; x++)
            cov_map[(y * cols + x) % STORE_DEPTH] = 1'b1;
      if (x0 + 1 >= cols) begin
         scan_c = 0;
         scan_r = y0 + 1;
      end else begin
         scan_c = x0 + 1;
         scan_r = y0;
      end
      w.x0 = CORNER_W'(x0);
      w.y0 = CORNER_W'(y0);
      w.x1 = CORNER_W'(x1);
      w.y1 = CORNER_W'(y1);
      pending_rects.push_back(w);
   endtask

   always @(posedge clock) begin
      rect_word_t want;
      if (reset) begin
         cols_q   = GRID_COLS_RST;
         rows_q   = GRID_ROWS_RST;
         mask_q   = WALL_MASK_RST;
         load_ptr = 0;
         drop_scan();
         pending_rects.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_rects.size() == 0) begin
               report_mismatch("unexpected result strobe", 1, 0);
            end else begin
               want = pending_rects.pop_front();
               if (rsp_rect_x0 !== want.x0)
                  report_mismatch("rect_x0", rsp_rect_x0, want.x0);
               if (rsp_rect_y0 !== want.y0)
                  report_mismatch("rect_y0", rsp_rect_y0, want.y0);
               if (rsp_rect_x1 !== want.x1)
                  report_mismatch("rect_x1", rsp_rect_x1, want.x1);
               if (rsp_rect_y1 !== want.y1)
                  report_mismatch("rect_y1", rsp_rect_y1, want.y1);
               if (rsp_done_res !== want.done)
                  report_mismatch("done_res", rsp_done_res, want.done);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_COLS: begin
                  cols_q = csr_data[GRID_REG_W-1:0];
                  drop_scan();
               end
               CSR_GRID_ROWS: begin
                  rows_q = csr_data[GRID_REG_W-1:0];
                  drop_scan();
               end
               CSR_WALL_MASK: begin
                  mask_q = csr_data[MASK_W-1:0];
                  drop_scan();
               end
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_opcode == OP_LOAD)
               store_code(req_cell_value);
            else
               predict_rect();
         end
      end
      rect_pending = pending_rects.size();
   end

endmodule

/* dv/tb.sv */
module tb;
   import wgrm_pkg::*;

   // Index with no register behind it; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   // Stall limit for a fetch over the 4096-cell grid; allow plenty
   localparam int STALL_LIMIT = 100000;
   localparam int ITEM_TARGET = 1700;
   localparam int GRID_CELLS  = MAX_COLS_DEF * MAX_ROWS_DEF;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_opcode;
   logic [CELL_IN_W-1:0]  req_cell_value;
   logic                  rsp_valid;
   logic [CORNER_W-1:0]   rsp_rect_x0;
   logic [CORNER_W-1:0]   rsp_rect_y0;
   logic [CORNER_W-1:0]   rsp_rect_x1;
   logic [CORNER_W-1:0]   rsp_rect_y1;
   logic                  rsp_done_res;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int fail_count;
   int rect_pending;
   int idle_pct;
   int item_count;
   int done_count;
   int stall_cycles;
   int cur_area;

   wall_grid_rectangle_merge_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_rect_x0    (rsp_rect_x0),
      .rsp_rect_y0    (rsp_rect_y0),
      .rsp_rect_x1    (rsp_rect_x1),
      .rsp_rect_y1    (rsp_rect_y1),
      .rsp_done_res   (rsp_done_res),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // Watch both channels, predict every fetch and compare each result word
   rect_cover_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_rect_x0    (rsp_rect_x0),
      .rsp_rect_y0    (rsp_rect_y0),
      .rsp_rect_x1    (rsp_rect_x1),
      .rsp_rect_y1    (rsp_rect_y1),
      .rsp_done_res   (rsp_done_res),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .rect_pending   (rect_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Count done words so a frame knows when its cover ran out.
   // Read right after an edge, this lags by one word; that only adds a fetch.
   always @(posedge clock) begin
      if (reset)
         done_count <= 0;
      else if (rsp_valid && rsp_done_res)
         done_count <= done_count + 1;
   end

   // Watchdog: end the run if no word moves on any channel for too long
   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Present one input word and hold it until the block takes it.
   // Idle cycles go in front; while start is low, toggle the payload as noise.
   task automatic send_word(input logic op, input logic [CELL_IN_W-1:0] code);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start          = 1'b0;
         req_opcode     = $urandom_range(1);
         req_cell_value = $urandom_range(15);
      end
      @(negedge clock);
      start          = 1'b1;
      req_opcode     = op;
      req_cell_value = code;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      item_count++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drop start, drain every expected result, then pause and wait out busy so a
   // trailing load is finished before the next register write.
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (rect_pending != 0)
         @(negedge clock);
      repeat (4)
         @(negedge clock);
      while (busy)
         @(negedge clock);
   endtask

   task automatic fetch_words(input int n);
      repeat (n)
         send_word(OP_FETCH, $urandom_range(15));
   endtask

   // Pick a grid shape and wall mask; mostly small grids, some extremes.
   // Grid registers get junk in the data bits above the register width.
   task automatic pick_config();
      int          r, cols, rows;
      logic [8:0]  junk_c, junk_r;
      logic [15:0] mask;
      r = $urandom_range(99);
      if (r < 70) begin
         cols = $urandom_range(1, 8);
         rows = $urandom_range(1, 8);
      end else if (r < 78) begin
         cols = $urandom_range(1, 2);
         rows = $urandom_range(32, 64);
      end else if (r < 86) begin
         cols = $urandom_range(33, 64);
         rows = $urandom_range(1, 2);
      end else if (r < 90) begin
         cols = $urandom_range(65, 127);
         rows = 1;
      end else if (r < 94) begin
         if ($urandom_range(1)) begin
            cols = 0;
            rows = $urandom_range(1, 8);
         end else begin
            cols = $urandom_range(1, 8);
            rows = 0;
         end
      end else begin
         cols = $urandom_range(9, 16);
         rows = $urandom_range(9, 16);
      end
      r = $urandom_range(99);
      if (r < 15)
         mask = 16'hFFFF;
      else if (r < 25)
         mask = 16'h0000;
      else if (r < 35)
         mask = 16'h0001 << $urandom_range(15);
      else
         mask = $urandom;
      junk_c = $urandom_range(511);
      junk_r = $urandom_range(511);
      write_csr(CSR_GRID_COLS, {junk_c, 7'(cols)});
      write_csr(CSR_GRID_ROWS, {junk_r, 7'(rows)});
      write_csr(CSR_WALL_MASK, mask);
      cur_area = ((cols > MAX_COLS_DEF) ? MAX_COLS_DEF : cols)
               * ((rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows);
   endtask

   // Well-formed frame: load the whole area, then fetch until done comes back.
   // A quarter of the cells repeat one code so larger blocks form.
   task automatic load_and_cover(input int area);
      int n, fetches, done_base, base, code;
      n    = (area == 0) ? 3 : area;
      base = $urandom_range(15);
      repeat (n) begin
         code = ($urandom_range(3) == 0) ? base : $urandom_range(15);
         send_word(OP_LOAD, 4'(code));
      end
      done_base = done_count;
      fetches   = 0;
      while (done_count == done_base && fetches < n + 2) begin
         send_word(OP_FETCH, $urandom_range(15));
         fetches++;
      end
   endtask

   // Broken sequence: loads and fetches mixed at random
   task automatic noise_burst();
      int n;
      n = $urandom_range(5, 30);
      repeat (n)
         send_word($urandom_range(1), $urandom_range(15));
   endtask

   initial begin
      int phase;
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_LOAD;
      req_cell_value = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_GRID_COLS;
      csr_data       = '0;
      idle_pct       = 0;
      item_count     = 0;
      cur_area       = GRID_CELLS;
      repeat (5)
         @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Fill the whole store once so no fetch can ever read an unloaded cell.
      // The 64 x 64 reset grid wraps the load pointer back to zero at the end.
      repeat (GRID_CELLS)
         send_word(OP_LOAD, $urandom_range(15));

      // Reset settings: empty mask, so the scan finds nothing
      fetch_words(1);

      // Every code a wall on the full grid: one full-size rectangle, then done
      // from a scan over covered cells, then a new scan from the top
      settle();
      write_csr(CSR_WALL_MASK, 16'hFFFF);
      fetch_words(3);

      // Write to the unused index: scan must survive, so this fetch is done
      settle();
      write_csr(CSR_SPARE, 16'hFFFF);
      fetch_words(1);

      // 3 x 2 grid, codes 0 and 15 are walls:
      //   row 0: . W W    row 1: W W W
      // Second rectangle grows right over covered cells and overlaps the first.
      settle();
      write_csr(CSR_GRID_COLS, 16'hFF83);
      write_csr(CSR_GRID_ROWS, 16'h0002);
      write_csr(CSR_WALL_MASK, 16'h8001);
      send_word(OP_LOAD, 4'd3);
      send_word(OP_LOAD, 4'd15);
      send_word(OP_LOAD, 4'd0);
      send_word(OP_LOAD, 4'd0);
      send_word(OP_LOAD, 4'd15);
      send_word(OP_LOAD, 4'd0);
      fetch_words(4);
      // Load in the middle of a scan: cancel it, next fetch starts over
      send_word(OP_LOAD, 4'd15);
      fetch_words(2);

      // No columns: always done, loads wrap at the full store depth
      settle();
      write_csr(CSR_GRID_COLS, 16'hFF80);
      fetch_words(1);
      send_word(OP_LOAD, 4'd5);
      send_word(OP_LOAD, 4'd10);

      // Column count above the maximum acts as the maximum
      settle();
      write_csr(CSR_GRID_COLS, 16'h007F);
      write_csr(CSR_GRID_ROWS, 16'h0001);
      fetch_words(2);

      // Shrink below the load pointer: the next load writes, then wraps
      settle();
      write_csr(CSR_GRID_COLS, 16'h0002);
      send_word(OP_LOAD, 4'd0);
      fetch_words(1);

      // No rows: always done
      settle();
      write_csr(CSR_GRID_COLS, 16'h0005);
      write_csr(CSR_GRID_ROWS, 16'h0000);
      fetch_words(1);

      // Random part: mostly whole frames, some noise; rotate the idle mix
      item_count = 0;
      phase      = 0;
      while (item_count < ITEM_TARGET) begin
         settle();
         case (phase % 4)
            1:       idle_pct = 79;
            2:       idle_pct = 28;
            default: idle_pct = 0;
         endcase
         pick_config();
         if ($urandom_range(99) < 80)
            load_and_cover(cur_area);
         else
            noise_burst();
         phase++;
      end

      // Drain, let the block go quiet, then give the verdict
      settle();
      repeat (8)
         @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
